// ===== hw/rtl/db2t_pkg.sv =====
package db2t_pkg;

  // Token codes as they appear on the result channel.
  typedef enum logic [2:0] {
    KIND_MINUS = 3'd0,
    KIND_POINT = 3'd1,
    KIND_PAIR  = 3'd2,
    KIND_ZEROS = 3'd3,
    KIND_ZERO  = 3'd4
  } token_kind_t;

  // Width of the digit position counter; covers the largest allowed number length.
  localparam int POS_W = 5;

  // One input byte never gives more than three tokens.
  localparam int MAX_TOKENS = 3;

  // Excess codes of the exponent and digit bytes.
  localparam logic [7:0] EXP_ZERO       = 8'd128;
  localparam logic [7:0] POS_EXP_BIAS   = 8'd192;
  localparam logic [7:0] NEG_EXP_BIAS   = 8'd63;
  localparam logic [7:0] NEG_DIGIT_BIAS = 8'd101;
  localparam logic [7:0] POS_DIGIT_MAX  = 8'd100;
  localparam logic [7:0] NEG_DIGIT_MIN  = 8'd2;
  localparam logic [6:0] PAIR_MAX       = 7'd99;

  typedef struct packed {
    token_kind_t kind;
    logic [6:0]  pair;
    logic [6:0]  zeros;
  } token_t;

  // All tokens caused by one byte, in emission order from index 0.
  typedef struct packed {
    token_t [MAX_TOKENS-1:0] tok;
    logic [1:0]              count;
  } bundle_t;

  // Running state of the number being converted.
  typedef struct packed {
    logic             awaiting;
    logic             negative;
    logic [7:0]       int_pairs;
    logic [POS_W-1:0] position;
    logic             point_done;
  } num_state_t;

  localparam num_state_t STATE_RESET = '{
    awaiting:   1'b1,
    negative:   1'b0,
    int_pairs:  8'd0,
    position:   '0,
    point_done: 1'b0
  };

endpackage

// ===== hw/rtl/db2t_decode.sv =====
module db2t_decode #(
  parameter int MAX_NUMBER_BYTES = 22
) (
  input  db2t_pkg::num_state_t cur,
  input  logic [7:0]           code_byte,
  input  logic                 final_byte,
  output db2t_pkg::bundle_t    bundle,
  output db2t_pkg::num_state_t nxt
);
  import db2t_pkg::*;

  localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_NUMBER_BYTES);
  localparam logic [POS_W-1:0] FIRST_POS = POS_W'(1);
  localparam int NCAND = 6;

  logic signed [8:0] ib;
  logic signed [8:0] pos_s;
  logic signed [8:0] mag;
  logic signed [8:0] exp_pos;
  logic signed [8:0] exp_neg;
  logic signed [8:0] lead_cnt;
  logic signed [8:0] trail_cnt;
  logic              live;
  logic              point_cond;
  logic              f_zero, f_minus, f_point, f_lead, f_pair, f_trail;
  logic [6:0]        pair_val;
  logic [6:0]        pos_pair;
  logic [6:0]        neg_pair;
  token_t [NCAND-1:0] cand;
  logic [NCAND-1:0]   cand_on;
  logic [1:0]         n;

  // Signed views of the stored state and the incoming exponent.
  assign ib      = signed'({cur.int_pairs[7], cur.int_pairs});
  assign pos_s   = signed'({{(9-POS_W){1'b0}}, cur.position});
  assign mag     = (ib < 0) ? -ib : ib;
  assign exp_pos = signed'({1'b0, code_byte}) - signed'({1'b0, POS_EXP_BIAS});
  assign exp_neg = signed'({1'b0, NEG_EXP_BIAS}) - signed'({1'b0, code_byte});
  assign live       = cur.position < MAX_POS;
  assign point_cond = !cur.point_done && (pos_s > ib);

  // Digit values, clamped where the byte lies outside the legal range.
  assign pos_pair = (code_byte == 8'd0) ? 7'd0 :
                    (code_byte > POS_DIGIT_MAX) ? PAIR_MAX : 7'(code_byte - 8'd1);
  assign neg_pair = (code_byte < NEG_DIGIT_MIN) ? PAIR_MAX :
                    (code_byte > NEG_DIGIT_BIAS) ? 7'd0 : 7'(NEG_DIGIT_BIAS - code_byte);

  // Decide which tokens this byte causes and the state it leaves behind.
  always_comb begin
    nxt       = cur;
    f_zero    = 1'b0;
    f_minus   = 1'b0;
    f_point   = 1'b0;
    f_lead    = 1'b0;
    f_pair    = 1'b0;
    f_trail   = 1'b0;
    lead_cnt  = '0;
    trail_cnt = '0;
    pair_val  = '0;
    if (cur.awaiting) begin
      nxt.point_done = 1'b0;
      nxt.position   = FIRST_POS;
      if (final_byte) begin
        f_zero        = 1'b1;
        nxt.negative  = 1'b0;
        nxt.int_pairs = 8'd0;
      end else if (code_byte == EXP_ZERO) begin
        // Zero with trailing bytes: the rest of the number is swallowed.
        f_zero         = 1'b1;
        nxt.negative   = 1'b0;
        nxt.int_pairs  = 8'd0;
        nxt.point_done = 1'b1;
        nxt.position   = MAX_POS;
        nxt.awaiting   = 1'b0;
      end else if (code_byte > EXP_ZERO) begin
        nxt.negative  = 1'b0;
        nxt.int_pairs = exp_pos[7:0];
        nxt.awaiting  = 1'b0;
        if (exp_pos < 0) begin
          f_point        = 1'b1;
          f_lead         = 1'b1;
          lead_cnt       = -exp_pos;
          nxt.point_done = 1'b1;
        end
      end else begin
        f_minus       = 1'b1;
        nxt.negative  = 1'b1;
        nxt.int_pairs = exp_neg[7:0];
        nxt.awaiting  = 1'b0;
      end
    end else begin
      if (!cur.negative) begin
        if (live) begin
          f_pair   = 1'b1;
          pair_val = pos_pair;
          if (point_cond) begin
            f_point        = 1'b1;
            nxt.point_done = 1'b1;
          end
        end
        if (final_byte) begin
          trail_cnt = ib - pos_s;
          f_trail   = trail_cnt > 0;
        end
      end else if (!final_byte) begin
        if (live) begin
          f_pair   = 1'b1;
          pair_val = neg_pair;
          if (point_cond) begin
            f_point        = 1'b1;
            nxt.point_done = 1'b1;
            if (ib <= 0) begin
              lead_cnt = mag;
              f_lead   = mag > 0;
            end
          end
        end
      end else if (pos_s <= mag) begin
        // Negative terminator: pad the remaining integer positions.
        if (point_cond) begin
          f_point        = 1'b1;
          nxt.point_done = 1'b1;
          if (ib <= 0) begin
            lead_cnt = mag;
            f_lead   = mag > 0;
          end
        end
        trail_cnt = mag - pos_s + 9'sd1;
        f_trail   = 1'b1;
      end
      if (live) begin
        nxt.position = cur.position + FIRST_POS;
      end
      if (final_byte) begin
        nxt.awaiting = 1'b1;
      end
    end
  end

  // Candidate tokens in the order they are emitted.
  always_comb begin
    cand[0] = '{kind: KIND_ZERO,  pair: 7'd0,    zeros: 7'd0};
    cand[1] = '{kind: KIND_MINUS, pair: 7'd0,    zeros: 7'd0};
    cand[2] = '{kind: KIND_POINT, pair: 7'd0,    zeros: 7'd0};
    cand[3] = '{kind: KIND_ZEROS, pair: 7'd0,    zeros: lead_cnt[6:0]};
    cand[4] = '{kind: KIND_PAIR,  pair: pair_val, zeros: 7'd0};
    cand[5] = '{kind: KIND_ZEROS, pair: 7'd0,    zeros: trail_cnt[6:0]};
    cand_on = {f_trail, f_pair, f_lead, f_point, f_minus, f_zero};
  end

  // Pack the active candidates into consecutive slots.
  always_comb begin
    bundle = '0;
    n      = 2'd0;
    for (int i = 0; i < NCAND; i++) begin
      if (cand_on[i] && (n < 2'(MAX_TOKENS))) begin
        bundle.tok[n] = cand[i];
        n             = n + 2'd1;
      end
    end
    bundle.count = n;
  end

endmodule

// ===== hw/rtl/db_number_to_decimal_text_unit.sv =====
// Converts a packed base-100 decimal number, fed one byte per word with the exponent byte
// first, into a stream of text tokens: minus, decimal point, two-digit pairs, runs of "00"
// pairs and a lone zero. Each byte is registered on entry and decoded combinationally into a
// group of up to three tokens, which is queued in a two-group buffer; the result channel
// then delivers one token per cycle while out_stall is low, so the sustained byte rate is set
// by the token count per byte on the single-token output port. Digit bytes past
// MAX_NUMBER_BYTES - 1 digit positions are dropped. An accepted byte reaches the result
// channel through the input register and then the token group buffer.
module db_number_to_decimal_text_unit #(
  parameter int MAX_NUMBER_BYTES = 22
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] code_byte,
  input  logic       final_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] token_kind,
  output logic [6:0] pair_value,
  output logic [6:0] zero_pairs,
  output logic       run_end
);
  import db2t_pkg::*;

  localparam int FIFO_DEPTH = 2;

  logic       in_reg_valid;
  logic [7:0] in_reg_byte;
  logic       in_reg_final;
  num_state_t num_state;
  num_state_t num_state_next;
  bundle_t    dec_bundle;

  bundle_t    fifo [FIFO_DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fifo_count;
  logic [1:0] tok_idx;

  logic       in_accept;
  logic       consume;
  logic       push;
  logic       pop;
  logic       out_accept;
  logic       last_tok;
  bundle_t    head;
  token_t     head_tok;

  // Decode of the registered byte against the running number state.
  db2t_decode #(
    .MAX_NUMBER_BYTES(MAX_NUMBER_BYTES)
  ) u_decode (
    .cur       (num_state),
    .code_byte (in_reg_byte),
    .final_byte(in_reg_final),
    .bundle    (dec_bundle),
    .nxt       (num_state_next)
  );

  // Handshake control: a byte moves on once its token group has room in the buffer.
  assign head       = fifo[rd_ptr];
  assign head_tok   = head.tok[tok_idx];
  assign last_tok   = tok_idx == (head.count - 2'd1);
  assign out_valid  = fifo_count != 2'd0;
  assign out_accept = out_valid && !out_stall;
  assign pop        = out_accept && last_tok;
  assign consume    = in_reg_valid && ((fifo_count != 2'(FIFO_DEPTH)) || pop);
  assign push       = consume && (dec_bundle.count != 2'd0);
  assign in_stall   = in_reg_valid && !consume;
  assign in_accept  = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_accept) begin
      in_reg_valid <= 1'b1;
    end else if (consume) begin
      in_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_reg_byte  <= code_byte;
      in_reg_final <= final_byte;
    end
  end

  // Number state advances once per decoded byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_state <= STATE_RESET;
    end else if (consume) begin
      num_state <= num_state_next;
    end
  end

  // Token group buffer storage.
  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= dec_bundle;
    end
  end

  // Buffer pointers, fill count and the token index within the head group.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= 1'b0;
      rd_ptr     <= 1'b0;
      fifo_count <= 2'd0;
      tok_idx    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr  <= !rd_ptr;
        tok_idx <= 2'd0;
      end else if (out_accept) begin
        tok_idx <= tok_idx + 2'd1;
      end
      fifo_count <= fifo_count + {1'b0, push} - {1'b0, pop};
    end
  end

  // Result word fields.
  assign token_kind = head_tok.kind;
  assign pair_value = head_tok.pair;
  assign zero_pairs = head_tok.zeros;
  assign run_end    = last_tok;

endmodule

// ===== tb/db_number_to_decimal_text_unit_tb.sv =====
`timescale 1ns / 100ps

module db_number_to_decimal_text_unit_tb;
  import db2t_pkg::*;

  localparam int MAX_NUMBER_BYTES = 22;
  localparam int WORD_COUNT       = 410;
  localparam int QUIET_WORDS      = 60;
  localparam int IDLE_LIMIT       = 1000;
  localparam int TAIL_CYCLES      = 20;
  localparam int MAX_PRINTED      = 100;
  localparam logic [7:0] NEG_TERMINATOR = 8'd102;

  // One text token as it should leave the result channel.
  typedef struct {
    token_kind_t kind;
    logic [6:0]  pair;
    logic [6:0]  zeros;
    logic        last;
  } text_token_t;

  // Tracks the number being converted and the tokens still owed by the block.
  class decimal_text_tracker;
    bit                 expecting_exp = 1'b1;
    bit                 minus_sign    = 1'b0;
    logic signed [7:0]  int_pair_count = '0;
    logic [POS_W-1:0]   digit_pos      = '0;
    bit                 point_out      = 1'b0;
    text_token_t        owed_tokens[$];
    int                 errors = 0;

    function int pending();
      return owed_tokens.size();
    endfunction

    function void add_token(token_kind_t k, int pair_v, int zero_v);
      text_token_t t;
      t.kind  = k;
      t.pair  = 7'(pair_v);
      t.zeros = 7'(zero_v);
      t.last  = 1'b0;
      owed_tokens.push_back(t);
    endfunction

    function void add_zero_run(int n);
      if (n > 0) add_token(KIND_ZEROS, 0, n);
    endfunction

    // Works out the tokens that one accepted word causes and advances the number state.
    function void note_byte(logic [7:0] b, logic fin);
      int first;
      int ib;
      int pos;
      int mag;
      int v;
      bit live;
      first = owed_tokens.size();
      if (expecting_exp) begin
        point_out = 1'b0;
        digit_pos = POS_W'(1);
        if (fin) begin
          add_token(KIND_ZERO, 0, 0);
          minus_sign     = 1'b0;
          int_pair_count = '0;
        end else if (b == EXP_ZERO) begin
          // A zero with trailing bytes: everything up to the last word is ignored.
          add_token(KIND_ZERO, 0, 0);
          minus_sign     = 1'b0;
          int_pair_count = '0;
          point_out      = 1'b1;
          digit_pos      = POS_W'(MAX_NUMBER_BYTES);
          expecting_exp  = 1'b0;
        end else if (b > EXP_ZERO) begin
          ib             = int'(b) - int'(POS_EXP_BIAS);
          minus_sign     = 1'b0;
          int_pair_count = 8'(ib);
          if (ib < 0) begin
            add_token(KIND_POINT, 0, 0);
            add_zero_run(-ib);
            point_out = 1'b1;
          end
          expecting_exp = 1'b0;
        end else begin
          ib             = int'(NEG_EXP_BIAS) - int'(b);
          minus_sign     = 1'b1;
          int_pair_count = 8'(ib);
          add_token(KIND_MINUS, 0, 0);
          expecting_exp  = 1'b0;
        end
      end else begin
        ib   = int_pair_count;
        pos  = int'(digit_pos);
        live = pos < MAX_NUMBER_BYTES;
        mag  = (ib < 0) ? -ib : ib;
        if (!minus_sign) begin
          if (live) begin
            v = (b == 8'd0) ? 0 : ((b > POS_DIGIT_MAX) ? int'(PAIR_MAX) : int'(b) - 1);
            if (!point_out && pos > ib) begin
              add_token(KIND_POINT, 0, 0);
              point_out = 1'b1;
            end
            add_token(KIND_PAIR, v, 0);
          end
          if (fin) add_zero_run(ib - pos);
        end else if (!fin) begin
          if (live) begin
            v = (b < NEG_DIGIT_MIN) ? int'(PAIR_MAX) :
                ((b > NEG_DIGIT_BIAS) ? 0 : int'(NEG_DIGIT_BIAS) - int'(b));
            if (!point_out && pos > ib) begin
              add_token(KIND_POINT, 0, 0);
              point_out = 1'b1;
              if (ib <= 0) add_zero_run(mag);
            end
            add_token(KIND_PAIR, v, 0);
          end
        end else if (pos <= mag) begin
          // The negative terminator pads the remaining integer positions with zeros.
          if (!point_out && pos > ib) begin
            add_token(KIND_POINT, 0, 0);
            point_out = 1'b1;
            if (ib <= 0) add_zero_run(mag);
          end
          add_zero_run(mag - pos + 1);
        end
        if (live) digit_pos = POS_W'(pos + 1);
        if (fin) expecting_exp = 1'b1;
      end
      if (owed_tokens.size() > first) owed_tokens[$].last = 1'b1;
    endfunction

    task report(string what);
      errors++;
      if (errors <= MAX_PRINTED) $display("mismatch at %0t: %s", $time, what);
    endtask

    // Compares an accepted token with the oldest one owed.
    task check_token(logic [2:0] k, logic [6:0] p, logic [6:0] z, logic e);
      text_token_t t;
      if (owed_tokens.size() == 0) begin
        report($sformatf("unexpected token kind %0d pair %0d zeros %0d end %0b", k, p, z, e));
        return;
      end
      t = owed_tokens.pop_front();
      if (k !== t.kind)
        report($sformatf("token_kind %0d, wanted %0d", k, t.kind));
      if (p !== t.pair)
        report($sformatf("pair_value %0d, wanted %0d (kind %0d)", p, t.pair, t.kind));
      if (z !== t.zeros)
        report($sformatf("zero_pairs %0d, wanted %0d (kind %0d)", z, t.zeros, t.kind));
      if (e !== t.last)
        report($sformatf("run_end %0b, wanted %0b (kind %0d)", e, t.last, t.kind));
    endtask
  endclass

  logic       clk        = 1'b0;
  logic       rst        = 1'b1;
  logic       in_valid   = 1'b0;
  logic       in_stall;
  logic [7:0] code_byte  = '0;
  logic       final_byte = 1'b0;
  logic       out_valid;
  logic       out_stall  = 1'b0;
  logic [2:0] token_kind;
  logic [6:0] pair_value;
  logic [6:0] zero_pairs;
  logic       run_end;

  decimal_text_tracker tracker = new();
  bit quiet       = 1'b0;
  int words_sent  = 0;
  int idle_cycles = 0;

  always #1 clk = ~clk;

  db_number_to_decimal_text_unit #(
    .MAX_NUMBER_BYTES(MAX_NUMBER_BYTES)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .code_byte (code_byte),
    .final_byte(final_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .token_kind(token_kind),
    .pair_value(pair_value),
    .zero_pairs(zero_pairs),
    .run_end   (run_end)
  );

  // Both handshakes are observed at the rising edge; the watchdog counts edges with no transfer.
  always @(posedge clk) begin : monitor
    bit moved;
    moved = 1'b0;
    if (!rst) begin
      if (in_valid && in_stall === 1'b0) begin
        tracker.note_byte(code_byte, final_byte);
        moved = 1'b1;
      end
      if (out_valid === 1'b1 && !out_stall) begin
        tracker.check_token(token_kind, pair_value, zero_pairs, run_end);
        moved = 1'b1;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("** db_number_to_decimal_text_unit: FAILED **");
        $finish;
      end
    end
  end

  // Result-side back-pressure: free runs broken by stall bursts, none in the quiet tail.
  initial begin : stall_gen
    int n;
    forever begin
      n = $urandom_range(1, 30);
      repeat (n) begin
        @(negedge clk);
        out_stall <= 1'b0;
      end
      if (!quiet && $urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, 19);
        repeat (n) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
      end
    end
  end

  // Offers one word, optionally after a gap, and returns once it has been taken.
  task automatic send_word(input logic [7:0] b, input logic fin, input bit calm);
    int gap;
    gap = (quiet || calm || $urandom_range(0, 4) != 0) ? 0 : $urandom_range(1, 19);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    code_byte  <= b;
    final_byte <= fin;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
  endtask

  // Holds the input back until every owed token has been delivered.
  task automatic drain_tokens();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
  endtask

  // Hand-picked numbers covering the sign, exponent and digit corner cases.
  task automatic send_directed();
    // Lone exponent marked final.
    send_word(8'd193, 1'b1, 1'b0);
    // Zero exponent followed by bytes that must be ignored.
    send_word(EXP_ZERO, 1'b0, 1'b0);
    send_word(8'd5, 1'b0, 1'b0);
    send_word(8'd7, 1'b1, 1'b0);
    // Positive fraction with leading zero pairs; digits out of range on both sides.
    send_word(8'd190, 1'b0, 1'b0);
    send_word(8'd0, 1'b0, 1'b0);
    send_word(8'd255, 1'b1, 1'b0);
    // Positive with no integer pairs: the point comes before the first digit.
    send_word(POS_EXP_BIAS, 1'b0, 1'b0);
    send_word(8'd100, 1'b1, 1'b0);
    // Negative with one integer pair; the terminator adds nothing.
    send_word(8'd62, 1'b0, 1'b0);
    send_word(8'd1, 1'b0, 1'b0);
    send_word(8'd255, 1'b0, 1'b0);
    send_word(NEG_TERMINATOR, 1'b1, 1'b0);
    // Negative fraction: point and zero run before the first digit, padding at the end.
    send_word(8'd65, 1'b0, 1'b0);
    send_word(NEG_DIGIT_BIAS, 1'b0, 1'b0);
    send_word(NEG_TERMINATOR, 1'b1, 1'b0);
    // Most negative exponent, terminated at once.
    send_word(8'd127, 1'b0, 1'b0);
    send_word(NEG_TERMINATOR, 1'b1, 1'b0);
    // Largest negative integer count.
    send_word(8'd0, 1'b0, 1'b0);
    send_word(8'd0, 1'b1, 1'b0);
    // Largest positive integer count.
    send_word(8'd255, 1'b0, 1'b0);
    send_word(8'd51, 1'b1, 1'b0);
    // Smallest positive exponent.
    send_word(8'd129, 1'b0, 1'b0);
    send_word(8'd2, 1'b1, 1'b0);
    words_sent += 24;
  endtask

  // One random number: mostly well formed, some lone zeros, ignored tails and noise.
  task automatic send_random_number();
    int r;
    int ib;
    int nd;
    bit neg;
    bit calm;
    logic [7:0] d;
    calm = ($urandom_range(0, 3) == 0);
    r    = $urandom_range(0, 99);
    if (r < 5) begin
      send_word(8'($urandom_range(0, 255)), 1'b1, calm);
      words_sent++;
    end else if (r < 10) begin
      send_word(EXP_ZERO, 1'b0, calm);
      words_sent++;
      nd = $urandom_range(0, 3);
      repeat (nd) send_word(8'($urandom_range(0, 255)), 1'b0, calm);
      send_word(8'($urandom_range(0, 255)), 1'b1, calm);
      words_sent += nd + 1;
    end else if (r < 16) begin
      send_word(8'($urandom_range(0, 255)), $urandom_range(0, 2) == 0, calm);
      words_sent++;
    end else begin
      neg = $urandom_range(0, 1);
      if ($urandom_range(0, 4) == 0)
        ib = neg ? int'($urandom_range(0, 127)) - 64 : int'($urandom_range(0, 126)) - 63;
      else
        ib = int'($urandom_range(0, 8)) - 3;
      // A few numbers run past the digit limit.
      nd = ($urandom_range(0, 14) == 0) ? $urandom_range(18, 26) : $urandom_range(1, 6);
      send_word(neg ? 8'(63 - ib) : 8'(192 + ib), 1'b0, calm);
      words_sent++;
      for (int i = 0; i < nd; i++) begin
        if ($urandom_range(0, 9) == 0) d = 8'($urandom_range(0, 255));
        else d = neg ? 8'($urandom_range(2, 101)) : 8'($urandom_range(1, 100));
        send_word(d, !neg && i == nd - 1, calm);
        words_sent++;
      end
      if (neg) begin
        d = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255)) : NEG_TERMINATOR;
        send_word(d, 1'b1, calm);
        words_sent++;
      end
    end
  endtask

  initial begin : main
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    send_directed();
    drain_tokens();

    while (words_sent < WORD_COUNT) begin
      if (words_sent >= WORD_COUNT - QUIET_WORDS) quiet = 1'b1;
      send_random_number();
      if (!quiet && $urandom_range(0, 24) == 0) drain_tokens();
    end

    drain_tokens();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("** db_number_to_decimal_text_unit: PASSED **");
    end else begin
      $display("** db_number_to_decimal_text_unit: FAILED **");
    end
    $finish;
  end

endmodule
